// ===== sv/mhd_pkg.sv =====
package mhd_pkg;

   localparam int HEAP_DEPTH  = 16;
   localparam int VALUE_BITS  = 16;
   localparam int FRAC_BITS   = 8;
   localparam int IDX_W       = $clog2(HEAP_DEPTH);
   localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);
   localparam int SUM_W       = VALUE_BITS + IDX_W;
   localparam int AVG_W       = VALUE_BITS + FRAC_BITS;
   localparam int DIVD_W      = SUM_W + FRAC_BITS;
   localparam int DIV_CNT_W   = $clog2(DIVD_W + 1);
   localparam int REQ_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = VALUE_BITS + IDX_W + CNT_W + AVG_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_TUSER_W = 2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DUMP   = 1'b1;

   localparam int USER_DROPPED = 0;
   localparam int USER_EMPTY   = 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIFT_CHK,
      ST_SIFT_CMP,
      ST_INS_OUT,
      ST_DIV_WAIT,
      ST_DUMP_RD,
      ST_DUMP_OUT,
      ST_EMPTY_OUT
   } state_type;

   typedef struct packed {
      logic                  en;
      logic [IDX_W-1:0]      addr;
      logic [VALUE_BITS-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic                  en;
      logic [IDX_W-1:0]      addr;
   } ram_rd_type;

endpackage

// ===== sv/mhd_ram.sv =====
module mhd_ram (
   input  logic                           clock,
   input  mhd_pkg::ram_wr_type            wr,
   input  mhd_pkg::ram_rd_type            rd,
   output logic [mhd_pkg::VALUE_BITS-1:0] rd_data
);
   import mhd_pkg::*;

   logic [VALUE_BITS-1:0] mem [HEAP_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

// ===== sv/mhd_div.sv =====
module mhd_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mhd_pkg::DIVD_W-1:0]  dividend,
   input  logic [mhd_pkg::CNT_W-1:0]   divisor,
   output logic                        done,
   output logic [mhd_pkg::AVG_W-1:0]   quotient
);
   import mhd_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [DIVD_W-1:0]    quo_ff, quo_in;
   logic [CNT_W:0]       trial;

   // restoring divide, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVD_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = CNT_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = CNT_W'(trial);
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[AVG_W-1:0];

endmodule

// ===== sv/min_heap_insert_and_dump_top.sv =====
// insert: sift-up runs SIFT_CHK then SIFT_CMP for each level climbed, then INS_OUT
// dropped insert or empty dump: goes straight from idle to its response state
// dump: waits for the 28-step average divider, then DUMP_RD and DUMP_OUT for each stored entry
// one item at a time; req_tready is high only between items
// results pass through a one-beat output register; a stall holds that beat and the sequencer waits
// reset clears entry count, running sum, sequencer and output valid; store contents undefined
module min_heap_insert_and_dump_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mhd_pkg::REQ_TDATA_W-1:0]  req_tdata,  // value
   input  logic                             req_tuser,  // mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mhd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // element, position, entries, average_fixed
   output logic                             rsp_tlast,  // is_last
   output logic [mhd_pkg::RSP_TUSER_W-1:0]  rsp_tuser   // dropped, empty_res
);
   import mhd_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [VALUE_BITS-1:0] root_ff, root_in;
   logic                  drop_ff, drop_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] elem_ff, elem_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic                  last_ff, last_in;
   logic [CNT_W-1:0]      ent_ff, ent_in;
   logic [AVG_W-1:0]      avg_ff, avg_in;
   logic                  dropped_ff, dropped_in;
   logic                  empty_ff, empty_in;

   ram_wr_type            ram_wr;
   ram_rd_type            ram_rd;
   logic [VALUE_BITS-1:0] ram_rdata;
   logic                  div_start;
   logic                  div_done;
   logic [AVG_W-1:0]      div_quo;

   logic                  accept;
   logic                  slot_free;
   logic                  rsp_load;
   logic                  heap_full;
   logic                  dump_last;
   logic [IDX_W-1:0]      parent;
   logic [VALUE_BITS-1:0] req_value;

   assign req_value = req_tdata[VALUE_BITS-1:0];
   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign heap_full = (count_ff == CNT_W'(HEAP_DEPTH));
   assign dump_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign parent    = IDX_W'(idx_ff - IDX_W'(1)) >> 1;

   mhd_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rdata)
   );

   mhd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_ff, FRAC_BITS'(0)}),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == MODE_INSERT) begin
                  state_in = heap_full ? ST_INS_OUT : ST_SIFT_CHK;
               end else begin
                  state_in = (count_ff == '0) ? ST_EMPTY_OUT : ST_DIV_WAIT;
               end
            end
         end
         ST_SIFT_CHK: begin
            state_in = (idx_ff == '0) ? ST_INS_OUT : ST_SIFT_CMP;
         end
         ST_SIFT_CMP: begin
            state_in = (ram_rdata > val_ff) ? ST_SIFT_CHK : ST_INS_OUT;
         end
         ST_INS_OUT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_DUMP_RD;
            end
         end
         ST_DUMP_RD: begin
            state_in = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            if (slot_free) begin
               state_in = dump_last ? ST_IDLE : ST_DUMP_RD;
            end
         end
         ST_EMPTY_OUT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready = 1'b0;
      ram_wr     = '0;
      ram_rd     = '0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      count_in   = count_ff;
      sum_in     = sum_ff;
      idx_in     = idx_ff;
      val_in     = val_ff;
      root_in    = root_ff;
      drop_in    = drop_ff;
      elem_in    = elem_ff;
      pos_in     = pos_ff;
      last_in    = last_ff;
      ent_in     = ent_ff;
      avg_in     = avg_ff;
      dropped_in = dropped_ff;
      empty_in   = empty_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               idx_in = '0;
               if (req_tuser == MODE_INSERT) begin
                  drop_in = heap_full;
                  if (!heap_full) begin
                     idx_in   = count_ff[IDX_W-1:0];
                     val_in   = req_value;
                     count_in = count_ff + CNT_W'(1);
                     sum_in   = sum_ff + SUM_W'(req_value);
                  end
               end else if (count_ff != '0) begin
                  div_start = 1'b1;
               end
            end
         end
         ST_SIFT_CHK: begin
            if (idx_ff == '0) begin
               ram_wr  = '{en: 1'b1, addr: '0, data: val_ff};
               root_in = val_ff;
            end else begin
               ram_rd = '{en: 1'b1, addr: parent};
            end
         end
         ST_SIFT_CMP: begin
            if (ram_rdata > val_ff) begin
               ram_wr = '{en: 1'b1, addr: idx_ff, data: ram_rdata};
               idx_in = parent;
            end else begin
               ram_wr = '{en: 1'b1, addr: idx_ff, data: val_ff};
            end
         end
         ST_INS_OUT: begin
            if (slot_free) begin
               rsp_load   = 1'b1;
               elem_in    = root_ff;
               pos_in     = '0;
               last_in    = 1'b1;
               ent_in     = count_ff;
               avg_in     = '0;
               dropped_in = drop_ff;
               empty_in   = 1'b0;
            end
         end
         ST_DIV_WAIT: begin
         end
         ST_DUMP_RD: begin
            ram_rd = '{en: 1'b1, addr: idx_ff};
         end
         ST_DUMP_OUT: begin
            if (slot_free) begin
               rsp_load   = 1'b1;
               elem_in    = ram_rdata;
               pos_in     = idx_ff;
               last_in    = dump_last;
               ent_in     = count_ff;
               avg_in     = dump_last ? div_quo : '0;
               dropped_in = 1'b0;
               empty_in   = 1'b0;
               idx_in     = idx_ff + IDX_W'(1);
            end
         end
         ST_EMPTY_OUT: begin
            if (slot_free) begin
               rsp_load   = 1'b1;
               elem_in    = '0;
               pos_in     = '0;
               last_in    = 1'b1;
               ent_in     = '0;
               avg_in     = '0;
               dropped_in = 1'b0;
               empty_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      val_ff     <= val_in;
      root_ff    <= root_in;
      drop_ff    <= drop_in;
      elem_ff    <= elem_in;
      pos_ff     <= pos_in;
      last_ff    <= last_in;
      ent_ff     <= ent_in;
      avg_ff     <= avg_in;
      dropped_ff <= dropped_in;
      empty_ff   <= empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = RSP_TDATA_W'({avg_ff, ent_ff, pos_ff, elem_ff});
   assign rsp_tuser  = {empty_ff, dropped_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HEAP_DEPTH))
      else $error("entry count above heap depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == MODE_INSERT && !heap_full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the heap");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside a dump");

   a_dump_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP_OUT |-> CNT_W'(idx_ff) < count_ff)
      else $error("dump position beyond stored entries");

endmodule
